// ===== rtl/core/round_robin_three_list_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ready queue core
// Shorthand for clocked implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREE_LIST_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_THREE_LIST_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define RRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and codes of the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int ID_BITS   = 8;
  localparam int OCC_BITS  = 5;
  localparam int MODE_BITS = 2;

  localparam logic [MODE_BITS-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PUTBACK = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_TAKE    = 2'd2;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [ID_BITS-1:0]   task_id;
  } req_t;

  typedef struct packed {
    logic                task_valid;
    logic [ID_BITS-1:0]  next_task;
    logic                insert_dropped;
    logic [OCC_BITS-1:0] occupancy;
  } rsp_t;

endpackage

// ===== rtl/core/rrq_store.sv =====
// ----------------------------------------------------------------------------
// rrq_store
// Linked-entry store: task id memory and next-link memory, one write and
// one registered read per memory each cycle.
// ----------------------------------------------------------------------------
module rrq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int PW    = 5
) (
  input  logic                       clk,
  input  logic [AW-1:0]              rd_addr,
  output logic [PW-1:0]              link_rd_data,
  output logic [rrq_pkg::ID_BITS-1:0] task_rd_data,
  input  logic                       link_wr_en,
  input  logic [AW-1:0]              link_wr_addr,
  input  logic [PW-1:0]              link_wr_data,
  input  logic                       task_wr_en,
  input  logic [AW-1:0]              task_wr_addr,
  input  logic [rrq_pkg::ID_BITS-1:0] task_wr_data
);
  import rrq_pkg::*;

  logic [PW-1:0]      link_mem [DEPTH];
  logic [ID_BITS-1:0] task_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (link_wr_en) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    link_rd_data <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (task_wr_en) begin
      task_mem[task_wr_addr] <= task_wr_data;
    end
    task_rd_data <= task_mem[rd_addr];
  end

endmodule

// ===== rtl/core/round_robin_three_list_queue_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_three_list_queue_core
// Round-robin ready queue: pending, round and active FIFO lists of task ids
// in one shared linked-entry store with a free list.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload | one transaction
//   --------+------------------------+---------+--------------------------------
//   req     | req_valid / req_stall  | req_t   | add, put back or take
//   rsp     | rsp_valid / rsp_stall  | rsp_t   | one result per request
//
// Each request has an accept and an execute cycle: the accept cycle issues the
// store read (and the splice link write on a take), the execute cycle writes
// back link and id and updates the list pointers. The registered store read
// sets that split. The response is registered; a new request is taken while
// the response is being taken, not while it stalls. Reset is synchronous: a
// fill mark tracks entries never handed out, so no clearing pass is needed.
//
module round_robin_three_list_queue_core #(
  parameter int ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rrq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rrq_pkg::rsp_t rsp
);
  import rrq_pkg::*;

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  // null link: one past the last entry
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  // transaction held between accept and execute
  logic [MODE_BITS-1:0] op;
  logic                 nop;
  logic [PW-1:0]        ent;
  logic [ID_BITS-1:0]   ins_id;
  logic                 was_fresh;
  logic                 fwd;
  logic [PW-1:0]        fwd_link;

  // list heads and tails, free list, fill mark, count
  logic [PW-1:0] pend_head, pend_tail;
  logic [PW-1:0] rnd_head, rnd_tail;
  logic [PW-1:0] act_head, act_tail;
  logic [PW-1:0] free_head;
  logic [PW-1:0] fresh;
  logic [PW-1:0] held_count;
  logic [PW-1:0] count_next;

  logic          accept;
  logic          is_insert;
  logic          act_empty, pend_any, round_any;
  logic [PW-1:0] take_head, take_tail;
  logic          splice, splice_wr;
  logic [PW-1:0] rd_ptr;

  logic          exec_ins, exec_take;
  logic          ins_round;
  logic [PW-1:0] ins_tail;
  logic [PW-1:0] take_next;

  logic               link_wr_en;
  logic [PW-1:0]      link_wr_ptr;
  logic [PW-1:0]      link_wr_data;
  logic [PW-1:0]      link_rd_data;
  logic [ID_BITS-1:0] task_rd_data;

  // Hold off requests in reset, during execute, and while a result stalls.
  assign req_stall = rst || (state == ST_EXEC) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign is_insert = (req.mode == MODE_ADD) || (req.mode == MODE_PUTBACK);

  // Take: with active empty, round becomes active and pending follows it.
  assign act_empty = (act_head == NIL);
  assign pend_any  = (pend_head != NIL);
  assign round_any = (rnd_head != NIL);
  assign take_head = act_empty ? (round_any ? rnd_head : pend_head) : act_head;
  assign take_tail = pend_any ? pend_tail : rnd_tail;
  assign splice    = act_empty && round_any && pend_any;
  // A one-entry round list gets its splice link forwarded instead: that
  // entry is freed in execute and its link is rewritten anyway.
  assign splice_wr = splice && (rnd_head != rnd_tail);
  assign rd_ptr    = (req.mode == MODE_TAKE) ? take_head : free_head;

  // Execute side.
  assign exec_ins  = (state == ST_EXEC) && !nop && ((op == MODE_ADD) || (op == MODE_PUTBACK));
  assign exec_take = (state == ST_EXEC) && !nop && (op == MODE_TAKE);
  assign ins_round = (op == MODE_PUTBACK);
  assign ins_tail  = ins_round ? rnd_tail : pend_tail;
  // A tail's link is never trusted: end of list is found by comparing to tail.
  assign take_next = (ent == act_tail) ? NIL : (fwd ? fwd_link : link_rd_data);

  always_comb begin
    count_next = held_count;
    if (exec_ins) begin
      count_next = held_count + PW'(1);
    end else if (exec_take) begin
      count_next = held_count - PW'(1);
    end
  end

  // One link write per cycle: splice at accept, append or free at execute.
  always_comb begin
    link_wr_en   = 1'b0;
    link_wr_ptr  = rnd_tail;
    link_wr_data = pend_head;
    if (accept && (req.mode == MODE_TAKE) && splice_wr) begin
      link_wr_en = 1'b1;
    end else if (exec_ins && (ins_tail != NIL)) begin
      link_wr_en   = 1'b1;
      link_wr_ptr  = ins_tail;
      link_wr_data = ent;
    end else if (exec_take) begin
      link_wr_en   = 1'b1;
      link_wr_ptr  = ent;
      link_wr_data = free_head;
    end
  end

  rrq_store #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .PW    (PW)
  ) u_store (
    .clk          (clk),
    .rd_addr      (rd_ptr[AW-1:0]),
    .link_rd_data (link_rd_data),
    .task_rd_data (task_rd_data),
    .link_wr_en   (link_wr_en),
    .link_wr_addr (link_wr_ptr[AW-1:0]),
    .link_wr_data (link_wr_data),
    .task_wr_en   (exec_ins),
    .task_wr_addr (ent[AW-1:0]),
    .task_wr_data (ins_id)
  );

  // Control state and list pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      pend_head  <= NIL;
      pend_tail  <= NIL;
      rnd_head   <= NIL;
      rnd_tail   <= NIL;
      act_head   <= NIL;
      act_tail   <= NIL;
      free_head  <= '0;
      fresh      <= '0;
      held_count <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
            if ((req.mode == MODE_TAKE) && act_empty) begin
              act_head  <= take_head;
              act_tail  <= take_tail;
              rnd_head  <= NIL;
              rnd_tail  <= NIL;
              pend_head <= NIL;
              pend_tail <= NIL;
            end
          end
        end
        ST_EXEC: begin
          state      <= ST_IDLE;
          rsp_valid  <= 1'b1;
          held_count <= count_next;
          if (exec_ins) begin
            if (ins_round) begin
              if (rnd_tail == NIL) begin
                rnd_head <= ent;
              end
              rnd_tail <= ent;
            end else begin
              if (pend_tail == NIL) begin
                pend_head <= ent;
              end
              pend_tail <= ent;
            end
            // Untouched entries chain to the next index by construction.
            if (was_fresh) begin
              free_head <= fresh + PW'(1);
              fresh     <= fresh + PW'(1);
            end else begin
              free_head <= link_rd_data;
            end
          end
          if (exec_take) begin
            act_head <= take_next;
            if (ent == act_tail) begin
              act_tail <= NIL;
            end
            free_head <= ent;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Transaction payload captured at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= req.mode;
      ins_id    <= req.task_id;
      ent       <= is_insert ? free_head : take_head;
      was_fresh <= (free_head == fresh);
      fwd       <= splice && (rnd_head == rnd_tail);
      fwd_link  <= pend_head;
      if (is_insert) begin
        nop <= (free_head == NIL);
      end else if (req.mode == MODE_TAKE) begin
        nop <= (take_head == NIL);
      end else begin
        nop <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      rsp.task_valid     <= exec_take;
      rsp.next_task      <= exec_take ? task_rd_data : '0;
      rsp.insert_dropped <= nop && ((op == MODE_ADD) || (op == MODE_PUTBACK));
      rsp.occupancy      <= OCC_BITS'(count_next);
    end
  end

endmodule

// ===== rtl/core/rrq_checker.sv =====
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks of the ready queue core, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_three_list_queue_core_macros.svh"

module rrq_checker #(
  parameter int ENTRIES = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input rrq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rrq_pkg::rsp_t rsp
);
  import rrq_pkg::*;

  // a stalled result holds
  `RRQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // one transaction in flight: the cycle after an accept is stalled
  `RRQ_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall, "request accepted back to back")

  // every accepted transaction shows its result right after the execute cycle
  `RRQ_ASSERT_NEXT(a_rsp_follow, req_valid && !req_stall, ##1 rsp_valid, "no result after accept")

  // an insert is dropped only with the store full
  `RRQ_ASSERT_NOW(a_drop_full, rsp_valid && rsp.insert_dropped, rsp.occupancy == OCC_BITS'(ENTRIES), "drop with free entries")

  // no task means a zero id
  `RRQ_ASSERT_NOW(a_zero_id, rsp_valid && !rsp.task_valid, rsp.next_task == '0, "nonzero id without task")

endmodule

bind round_robin_three_list_queue_core rrq_checker #(.ENTRIES(ENTRIES)) u_checker (.*);
